// File: rtl/sorted_priority_queue_top_macros.svh
// assertion macros for the sorted priority queue
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq check failed");

// next-cycle implication, disabled during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

// File: rtl/spq_pkg.sv
package spq_pkg;

  localparam int VALUE_W     = 32;
  localparam int IN_PRI_W    = 8;
  localparam int OCC_W       = 5;
  localparam int S_TDATA_W   = 40;
  localparam int M_TDATA_W   = 40;
  localparam int S_TUSER_W   = 1;
  localparam int M_TUSER_W   = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

// File: rtl/spq_cell.sv
module spq_cell #(
  parameter int PRIORITY_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  spq_pkg::cell_ctl_t           ctl,
  input  logic [spq_pkg::VALUE_W-1:0]  new_val,
  input  logic [PRIORITY_BITS-1:0]     new_pri,
  input  logic                         left_keep,
  input  logic                         left_valid,
  input  logic [spq_pkg::VALUE_W-1:0]  left_val,
  input  logic [PRIORITY_BITS-1:0]     left_pri,
  input  logic                         right_valid,
  input  logic [spq_pkg::VALUE_W-1:0]  right_val,
  input  logic [PRIORITY_BITS-1:0]     right_pri,
  output logic                         keep,
  output logic                         valid,
  output logic [spq_pkg::VALUE_W-1:0]  val,
  output logic [PRIORITY_BITS-1:0]     pri
);
  import spq_pkg::*;

  logic                     valid_next;
  logic [VALUE_W-1:0]       val_next;
  logic [PRIORITY_BITS-1:0] pri_next;

  // entries at or ahead of the new priority stay put
  assign keep = valid && (pri <= new_pri);

  always_comb begin
    valid_next = valid;
    val_next   = val;
    pri_next   = pri;
    if (ctl.ins && !keep) begin
      if (left_keep) begin
        valid_next = 1'b1;
        val_next   = new_val;
        pri_next   = new_pri;
      end else begin
        valid_next = left_valid;
        val_next   = left_val;
        pri_next   = left_pri;
      end
    end else if (ctl.rem) begin
      valid_next = right_valid;
      val_next   = right_val;
      pri_next   = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
    pri <= pri_next;
  end

endmodule

// File: rtl/sorted_priority_queue_top.sv
// a result beat is presented in the cycle after its input beat is accepted
// throughput: one insert or remove per cycle while s_axis_tready is high, all cells shift in parallel
// s_axis_tready drops only while a result beat waits on m_axis_tready
// rst (synchronous, active high) empties the queue and clears the output valid
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // item_value, item_priority
  input  logic [spq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [spq_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // removed_value, occupancy, zero pad
  output logic [spq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // status
  output logic [spq_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                     accept;
  op_t                      op;
  logic [VALUE_W-1:0]       in_val;
  logic [PRIORITY_BITS-1:0] in_pri;
  logic                     full;
  logic                     empty;
  cell_ctl_t                ctl;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;

  logic                     out_valid;
  logic [VALUE_W-1:0]       out_val;
  status_t                  out_status;
  logic [OCC_W-1:0]         out_occ;
  logic [VALUE_W-1:0]       res_val;
  status_t                  res_status;

  logic                     cell_keep  [QUEUE_DEPTH];
  logic                     cell_valid [QUEUE_DEPTH];
  logic [VALUE_W-1:0]       cell_val   [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri   [QUEUE_DEPTH];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_t'(s_axis_tuser[0]);
  assign in_val        = s_axis_tdata[VALUE_W-1:0];
  assign in_pri        = PRIORITY_BITS'(s_axis_tdata[VALUE_W +: IN_PRI_W]);

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);

  assign ctl.ins = accept && (op == OP_INSERT) && !full;
  assign ctl.rem = accept && (op == OP_REMOVE) && !empty;

  genvar i;
  generate
    for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                     l_keep;
      logic                     l_valid;
      logic [VALUE_W-1:0]       l_val;
      logic [PRIORITY_BITS-1:0] l_pri;
      logic                     r_valid;
      logic [VALUE_W-1:0]       r_val;
      logic [PRIORITY_BITS-1:0] r_pri;

      if (i == 0) begin : g_head
        assign l_keep  = 1'b1;
        assign l_valid = 1'b0;
        assign l_val   = '0;
        assign l_pri   = '0;
      end else begin : g_body
        assign l_keep  = cell_keep[i-1];
        assign l_valid = cell_valid[i-1];
        assign l_val   = cell_val[i-1];
        assign l_pri   = cell_pri[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_val   = '0;
        assign r_pri   = '0;
      end else begin : g_inner
        assign r_valid = cell_valid[i+1];
        assign r_val   = cell_val[i+1];
        assign r_pri   = cell_pri[i+1];
      end

      spq_cell #(
        .PRIORITY_BITS (PRIORITY_BITS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_val     (in_val),
        .new_pri     (in_pri),
        .left_keep   (l_keep),
        .left_valid  (l_valid),
        .left_val    (l_val),
        .left_pri    (l_pri),
        .right_valid (r_valid),
        .right_val   (r_val),
        .right_pri   (r_pri),
        .keep        (cell_keep[i]),
        .valid       (cell_valid[i]),
        .val         (cell_val[i]),
        .pri         (cell_pri[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    res_val = '0;
    if (op == OP_INSERT) begin
      res_status = full ? ST_FULL : ST_INSERTED;
    end else if (empty) begin
      res_status = ST_EMPTY;
    end else begin
      res_status = ST_REMOVED;
      res_val    = cell_val[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_val    <= res_val;
      out_status <= res_status;
      out_occ    <= OCC_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - OCC_W){1'b0}}, out_occ, out_val};
  assign m_axis_tuser  = out_status;

endmodule

// File: rtl/spq_checker.sv
`include "sorted_priority_queue_top_macros.svh"

module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [spq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [spq_pkg::M_TUSER_W-1:0]  m_axis_tuser
);
  import spq_pkg::*;

  `SPQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `SPQ_ASSERT_NOW(a_ready_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)
  `SPQ_ASSERT_NOW(a_empty_result, m_axis_tvalid && (m_axis_tuser == ST_EMPTY),
    m_axis_tdata == '0)
  `SPQ_ASSERT_NOW(a_full_result, m_axis_tvalid && (m_axis_tuser == ST_FULL),
    (m_axis_tdata[VALUE_W +: OCC_W] == OCC_W'(QUEUE_DEPTH)) &&
    (m_axis_tdata[VALUE_W-1:0] == '0))
  `SPQ_ASSERT_NEXT(a_insert_follow,
    m_axis_tvalid && m_axis_tready && (m_axis_tuser == ST_INSERTED) &&
    !(s_axis_tvalid && s_axis_tready),
    !m_axis_tvalid)

endmodule

bind sorted_priority_queue_top spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
    logic [OCC_W-1:0]   occ;
  } spq_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // item_value, item_priority
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  // opcode
  logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // removed_value, occupancy, zero pad
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  // status
  logic [M_TUSER_W-1:0]  m_axis_tuser;

  // mirror of the sorted store
  logic [VALUE_W-1:0]    held_val [DEPTH];
  logic [IN_PRI_W-1:0]   held_pri [DEPTH];
  int unsigned           held_n;

  spq_result_t           pending_results [$];
  spq_result_t           got_res;
  spq_result_t           want_res;
  int                    mismatch_count = 0;
  int                    src_idle_pct = 0;
  int                    sink_idle_pct = 0;
  int                    quiet_cycles = 0;

  sorted_priority_queue_top #(
    .QUEUE_DEPTH  (DEPTH),
    .PRIORITY_BITS(IN_PRI_W)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // sorted insert after equal priorities, pop from head
  function automatic void predict_queue_op(op_t op, logic [VALUE_W-1:0] val,
                                           logic [IN_PRI_W-1:0] pri);
    spq_result_t r;
    int unsigned pos;
    r = '0;
    if (op == OP_INSERT) begin
      if (held_n >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_n && held_pri[pos] <= pri) pos++;
        for (int unsigned i = held_n; i > pos; i--) begin
          held_val[i] = held_val[i-1];
          held_pri[i] = held_pri[i-1];
        end
        held_val[pos] = val;
        held_pri[pos] = pri;
        held_n++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (held_n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.value = held_val[0];
        for (int unsigned i = 1; i < held_n; i++) begin
          held_val[i-1] = held_val[i];
          held_pri[i-1] = held_pri[i];
        end
        held_n--;
        r.status = ST_REMOVED;
      end
    end
    r.occ = held_n[OCC_W-1:0];
    pending_results.push_back(r);
  endfunction

  task automatic send_beat(op_t op, logic [VALUE_W-1:0] val, logic [IN_PRI_W-1:0] pri);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pri, val};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_queue_op(op, val, pri);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_res.value  = m_axis_tdata[VALUE_W-1:0];
      got_res.occ    = m_axis_tdata[VALUE_W +: OCC_W];
      got_res.status = status_t'(m_axis_tuser);
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: value %h status %0d occ %0d",
                   got_res.value, got_res.status, got_res.occ);
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.value !== want_res.value || got_res.status !== want_res.status ||
            got_res.occ !== want_res.occ ||
            m_axis_tdata[M_TDATA_W-1:VALUE_W+OCC_W] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp value %h status %0d occ %0d, got value %h status %0d occ %0d pad %h",
                     want_res.value, want_res.status, want_res.occ,
                     got_res.value, got_res.status, got_res.occ,
                     m_axis_tdata[M_TDATA_W-1:VALUE_W+OCC_W]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_empty_remove();
    send_beat(OP_REMOVE, 32'hFFFF_FFFF, 8'hFF);
    send_beat(OP_REMOVE, 32'h0000_0000, 8'h00);
  endtask

  // fill with extremes and ties, then overflow
  task automatic test_fill_and_overflow();
    send_beat(OP_INSERT, 32'h8000_0000, 8'd255);
    send_beat(OP_INSERT, 32'h7FFF_FFFF, 8'd0);
    send_beat(OP_INSERT, 32'h0000_0000, 8'd128);
    send_beat(OP_INSERT, 32'hFFFF_FFFF, 8'd0);
    send_beat(OP_INSERT, 32'h0000_0001, 8'd255);
    send_beat(OP_INSERT, 32'hAAAA_5555, 8'd128);
    for (int i = 0; i < 10; i++)
      send_beat(OP_INSERT, 32'h1000_0000 + i, 8'(i % 3 * 85));
    send_beat(OP_INSERT, 32'hDEAD_BEEF, 8'd0);
    send_beat(OP_INSERT, 32'h5555_AAAA, 8'd255);
  endtask

  task automatic test_head_removal();
    for (int i = 0; i < 5; i++)
      send_beat(OP_REMOVE, $urandom(), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_traffic(int n_items);
    int insert_pct;
    int burst;
    logic [IN_PRI_W-1:0] pri;
    while (n_items > 0) begin
      insert_pct = ($urandom_range(0, 1) == 1) ? 80 : 25;
      burst = $urandom_range(10, 40);
      for (int i = 0; i < burst && n_items > 0; i++) begin
        if ($urandom_range(0, 3) == 0) pri = 8'($urandom_range(0, 255));
        else pri = 8'($urandom_range(0, 5));
        if ($urandom_range(0, 99) < insert_pct) send_beat(OP_INSERT, $urandom(), pri);
        else send_beat(OP_REMOVE, $urandom(), pri);
        n_items--;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      held_val[i] = '0;
      held_pri[i] = '0;
    end
    held_n = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_remove();
    test_fill_and_overflow();
    test_head_removal();
    wait_drained();

    src_idle_pct = 23;
    sink_idle_pct = 63;
    test_random_traffic(270);
    wait_drained();

    src_idle_pct = 63;
    sink_idle_pct = 23;
    test_random_traffic(270);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(270);
    wait_drained();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
